[rtl/core/uart_baud_divisor_search_macros.svh]
// assertion macros for the baud divisor search block
// used by the modules under rtl/core that carry assertions
`ifndef UART_BAUD_DIVISOR_SEARCH_MACROS_SVH
`define UART_BAUD_DIVISOR_SEARCH_MACROS_SVH

// check that an antecedent implies a consequent in the next cycle
`define UBDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// check that a condition never holds
`define UBDS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("assertion failed");

`endif

[rtl/core/ubds_pkg.sv]
// shared constants and types for the baud divisor search block
// no dependencies
package ubds_pkg;
  localparam logic [31:0] ClkResetHz = 32'd32768;
  localparam int unsigned OsrFirst = 4;
  localparam int unsigned OsrLast = 32;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_D, ST_DIV_LO, ST_DIV_HI, ST_CMP, ST_DONE
  } srch_state_e;

  typedef struct packed {
    logic [26:0] baud;
    logic [31:0] clk;
  } job_t;
endpackage

[rtl/core/ubds_front.sv]
// front end: accepts requests, snapshots the clock register, queues jobs
// depends on ubds_pkg
module ubds_front import ubds_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [26:0] target_baud_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        busy_o,
  output logic        job_valid_o,
  output job_t        job_o,
  input  logic        job_pop_i
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;
  logic [31:0] src_clk_q;
  job_t        mem_q [Depth];
  logic [Aw-1:0] wr_q, rd_q;
  logic [Aw:0]   cnt_q;
  logic push;

  assign busy_o = (cnt_q == Depth[Aw:0]);
  assign push = start_i && !busy_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_clk_q <= ClkResetHz;
    end else if (cfg_we_i) begin
      src_clk_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{baud: target_baud_i, clk: src_clk_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (job_pop_i) rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(job_pop_i);
    end
  end

  `include "uart_baud_divisor_search_macros.svh"
  `UBDS_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, job_pop_i && cnt_q == '0)
  `UBDS_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > Depth[Aw:0])
  `UBDS_ASSERT_NEXT(a_push_valid, clk_i, rst_ni, push, job_valid_o)
endmodule

[rtl/core/ubds_div.sv]
// radix-2 restoring divider, 32 by 33 bits, one quotient bit per cycle
// depends on ubds_pkg
module ubds_div import ubds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [31:0] num_i,
  input  logic [32:0] den_i,
  output logic        done_o,
  output logic [31:0] quo_o
);
  logic [32:0] rem_q, rem_d, trial;
  logic [31:0] quo_q;
  logic [32:0] den_q;
  logic [5:0]  cnt_q;
  logic        run_q;

  always_comb begin
    rem_d = {rem_q[31:0], quo_q[31]};
    trial = rem_d - den_q;
  end

  assign quo_o = (den_q == '0) ? 32'hFFFF_FFFF : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (go_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'd32;
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          run_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (run_q) begin
      if (rem_d >= den_q) begin
        rem_q <= trial;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_d;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end
endmodule

[rtl/core/ubds_back.sv]
// back end: walks oversampling ratios, three divisions each, keeps the best pair
// depends on ubds_pkg and ubds_div
module ubds_back import ubds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        done_o,
  output logic [15:0] best_divisor_o,
  output logic [5:0]  best_oversampling_o
);
  srch_state_e state_q, state_d;
  logic [26:0] baud_q;
  logic [31:0] clk_q, best_err_q, err_lo_q;
  logic [5:0]  r_q, best_r_q;
  logic [15:0] d_q, best_d_q;
  logic [31:0] prod_q;
  logic        div_go, div_done;
  logic [31:0] div_quo;
  logic [32:0] div_den;
  logic [31:0] err_hi, err_lo;
  logic        pick_hi;
  logic [15:0] cand_d;

  ubds_div u_div (
    .clk_i, .rst_ni, .go_i(div_go), .num_i(clk_q), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_comb begin
    state_d = state_q;
    job_pop_o = 1'b0;
    div_den = {1'b0, prod_q};
    case (state_q)
      ST_IDLE: if (job_valid_i) begin
        job_pop_o = 1'b1;
        state_d = ST_DIV_D;
      end
      ST_DIV_D: if (div_done) state_d = ST_DIV_LO;
      ST_DIV_LO: if (div_done) state_d = ST_DIV_HI;
      ST_DIV_HI: if (div_done) state_d = ST_CMP;
      ST_CMP: state_d = (r_q == 6'(OsrLast)) ? ST_DONE : ST_DIV_D;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // err values for the finished divisions
  assign err_lo = err_lo_q;
  assign err_hi = {5'd0, baud_q} - div_quo;
  assign pick_hi = err_lo > err_hi;
  assign cand_d = pick_hi ? d_q + 16'd1 : d_q;

  // one divide is launched per step; the product is formed a step earlier
  logic launch_q;
  assign done_o = (state_q == ST_DONE);
  assign best_divisor_o = best_d_q;
  assign best_oversampling_o = best_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      launch_q <= 1'b0;
    end else begin
      state_q <= state_d;
      launch_q <= job_pop_o || (div_done && state_q != ST_DIV_HI) ||
                  (state_q == ST_CMP && r_q != 6'(OsrLast));
    end
  end

  // products are registered in the cycle before the divider is started
  always_comb div_go = launch_q;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      baud_q <= job_i.baud;
      clk_q <= job_i.clk;
      r_q <= 6'(OsrFirst);
      best_err_q <= {5'd0, job_i.baud};
      best_r_q <= '0;
      best_d_q <= '0;
      prod_q <= {job_i.baud, 5'd0} >> 3;
    end else begin
      case (state_q)
        ST_DIV_D: if (div_done) begin
          d_q <= (div_quo[15:0] == '0) ? 16'd1 : div_quo[15:0];
          prod_q <= 32'(r_q) * ((div_quo[15:0] == '0) ? 32'd1 : 32'(div_quo[15:0]));
        end
        ST_DIV_LO: if (div_done) begin
          err_lo_q <= div_quo - {5'd0, baud_q};
          prod_q <= 32'(r_q) * (32'(d_q) + 32'd1);
        end
        ST_DIV_HI: if (div_done) begin
          if ((pick_hi ? err_hi : err_lo) <= best_err_q) begin
            best_err_q <= pick_hi ? err_hi : err_lo;
            best_r_q <= r_q;
            best_d_q <= cand_d;
          end
        end
        ST_CMP: begin
          r_q <= r_q + 6'd1;
          prod_q <= {5'd0, baud_q} * 32'(r_q + 6'd1);
        end
        default: ;
      endcase
    end
  end

  `include "uart_baud_divisor_search_macros.svh"
  `UBDS_ASSERT_NEVER(a_r_range, clk_i, rst_ni, state_q != ST_IDLE &&
    state_q != ST_DONE && (r_q < 6'(OsrFirst) || r_q > 6'(OsrLast)))
  `UBDS_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, state_q == ST_IDLE)
  `UBDS_ASSERT_NEVER(a_pop_idle, clk_i, rst_ni, job_pop_o && state_q != ST_IDLE)
endmodule

[rtl/core/uart_baud_divisor_search.sv]
// the search walks 29 ratios, each with three divide steps (divisor, low error,
// high error) and a compare, then raises done_o; the one shared 32-step radix-2
// divider runs one division at a time, and the next request is popped only when idle
// a two-entry queue takes new requests while a search runs; busy when full
// done_o pulses one cycle with the result; the receiver cannot stall
// reset clears the queue and the search; the source clock register resets to 32768
module uart_baud_divisor_search import ubds_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [26:0] target_baud_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        done_o,
  output logic [15:0] best_divisor_o,
  output logic [5:0]  best_oversampling_o
);
  logic job_valid, job_pop;
  job_t job;

  ubds_front #(.Depth(Depth)) u_front (
    .clk_i, .rst_ni, .start_i(start), .target_baud_i, .cfg_we_i, .cfg_wdata_i,
    .busy_o(busy), .job_valid_o(job_valid), .job_o(job), .job_pop_i(job_pop)
  );

  ubds_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_i(job), .job_pop_o(job_pop),
    .done_o, .best_divisor_o, .best_oversampling_o
  );
endmodule

[dv/tb_uart_baud_divisor_search.sv]
// self-checking testbench for uart_baud_divisor_search
// depends on ubds_pkg and the block's rtl; predicts each search result and checks every beat
module tb_uart_baud_divisor_search;
  import ubds_pkg::*;

  typedef struct {
    logic [15:0] divisor;
    logic [5:0]  osr;
  } baud_choice_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [26:0] target_baud_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        done_o;
  logic [15:0] best_divisor_o;
  logic [5:0]  best_oversampling_o;

  logic [26:0]  pending_bauds[$];
  baud_choice_t expected_choices[$];
  logic [31:0]  src_clk_hz = ClkResetHz;
  int unsigned  n_errors = 0;
  int unsigned  n_accepted = 0;
  int unsigned  n_checked = 0;
  int unsigned  n_clk_settings = 1;

  always #2 clk_i = ~clk_i;

  uart_baud_divisor_search u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .target_baud_i      (target_baud_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .best_divisor_o     (best_divisor_o),
    .best_oversampling_o(best_oversampling_o)
  );

  // divide by zero gives all ones
  function automatic logic [31:0] div_or_ones(logic [31:0] num, logic [31:0] den);
    if (den == 0) return 32'hFFFF_FFFF;
    return num / den;
  endfunction

  function automatic baud_choice_t search_best_divisor(logic [26:0] baud_in,
                                                       logic [31:0] clk_hz);
    baud_choice_t best;
    logic [31:0]  baud;
    logic [31:0]  best_err;
    logic [31:0]  err_lo;
    logic [31:0]  err_hi;
    logic [31:0]  div;
    baud = {5'b0, baud_in};
    best_err = baud;
    best.divisor = '0;
    best.osr = '0;
    for (int unsigned r = OsrFirst; r <= OsrLast; r++) begin
      div = div_or_ones(clk_hz, baud * r) & 32'hFFFF;
      if (div == 0) div = 1;
      err_lo = div_or_ones(clk_hz, r * div) - baud;
      err_hi = baud - div_or_ones(clk_hz, r * (div + 1));
      if (err_lo > err_hi) begin
        err_lo = err_hi;
        div = (div + 1) & 32'hFFFF;
      end
      if (err_lo <= best_err) begin
        best_err = err_lo;
        best.divisor = div[15:0];
        best.osr = r[5:0];
      end
    end
    return best;
  endfunction

  // driver: holds a beat until accepted, idles at random outside the quiet stretch
  always @(posedge clk_i or negedge rst_ni) begin
    logic accepted;
    logic idle_now;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        expected_choices.push_back(search_best_divisor(target_baud_i, src_clk_hz));
        void'(pending_bauds.pop_front());
        n_accepted++;
      end
      idle_now = ($urandom_range(99) < 16) && !(n_accepted >= 80 && n_accepted < 140);
      if (start && !accepted) begin
        start <= 1'b1;
      end else if (pending_bauds.size() > 0 && !idle_now) begin
        start <= 1'b1;
        target_baud_i <= pending_bauds[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done beat is checked against the oldest prediction
  always @(posedge clk_i) begin
    baud_choice_t want;
    if (rst_ni && done_o) begin
      if (expected_choices.size() == 0) begin
        $display("%0t: unexpected result divisor=%0d osr=%0d", $time,
                 best_divisor_o, best_oversampling_o);
        n_errors++;
      end else begin
        want = expected_choices.pop_front();
        n_checked++;
        if (best_divisor_o !== want.divisor) begin
          $display("%0t: best_divisor expected %0d actual %0d", $time,
                   want.divisor, best_divisor_o);
          n_errors++;
        end
        if (best_oversampling_o !== want.osr) begin
          $display("%0t: best_oversampling expected %0d actual %0d", $time,
                   want.osr, best_oversampling_o);
          n_errors++;
        end
      end
    end
  end

  task automatic drain_searches();
    while (pending_bauds.size() > 0 || expected_choices.size() > 0 || start)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_src_clk(logic [31:0] hz);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= $urandom();
    src_clk_hz = hz;
    n_clk_settings++;
  endtask

  function automatic logic [26:0] random_baud();
    int unsigned pick;
    pick = $urandom_range(3);
    case (pick)
      0: return 27'($urandom_range(255));
      1: return 27'($urandom_range(1_000_000));
      2: begin
        case ($urandom_range(4))
          0: return 27'd9600;
          1: return 27'd19200;
          2: return 27'd115200;
          3: return 27'd921600;
          default: return 27'd3_000_000;
        endcase
      end
      default: return 27'($urandom());
    endcase
  endfunction

  initial begin
    logic [31:0] clk_settings[4];
    clk_settings = '{32'd48_000_000, 32'hFFFF_FFFF, 32'd0, 32'd16_000_000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset clock, field extremes, zero baud (divisor wraps), typical rates
    pending_bauds = '{27'd0, 27'd1, 27'd2, 27'h7FF_FFFF, 27'h400_0000, 27'd300,
                      27'd1024, 27'd8192, 27'd9600, 27'd32768, 27'd100_000,
                      27'd115200, 27'd1_000_000};
    drain_searches();
    // max clock with tiny bauds truncates the divisor, so nothing gets chosen
    write_src_clk(32'hFFFF_FFFF);
    pending_bauds = '{27'd1, 27'd2, 27'd3, 27'd0, 27'h7FF_FFFF};
    drain_searches();

    for (int p = 0; p < 5; p++) begin
      if (p < 4) write_src_clk(clk_settings[p]);
      else write_src_clk($urandom());
      for (int i = 0; i < 40; i++) pending_bauds.push_back(random_baud());
      drain_searches();
    end

    $display("covered %0d searches, %0d results checked, %0d source clock settings",
             n_accepted, n_checked, n_clk_settings);
    if (n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #(4 * 3_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ubds_pkg.sv
rtl/core/ubds_front.sv
rtl/core/ubds_div.sv
rtl/core/ubds_back.sv
rtl/core/uart_baud_divisor_search.sv
dv/tb_uart_baud_divisor_search.sv
